[hdl/pstt_pkg.sv]
// Package for the priority-sorted task table: sizes, codes, state encoding
// and the status-letter helpers. No dependencies.
`default_nettype none
package pstt_pkg;
	localparam int Depth = 16;
	localparam int IdxW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	typedef enum logic [2:0] {
		REQ_INSERT = 3'd0,
		REQ_DELETE = 3'd1,
		REQ_UPDATE = 3'd2,
		REQ_SEARCH = 3'd3,
		REQ_LIST   = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		RC_OK           = 3'd0,
		RC_BAD_STATUS   = 3'd1,
		RC_DUPLICATE    = 3'd2,
		RC_NOT_FOUND    = 3'd3,
		RC_EMPTY        = 3'd4,
		RC_BAD_PRIORITY = 3'd5,
		RC_FULL         = 3'd6,
		RC_NONE         = 3'd7
	} rc_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIND,
		ST_INS_POS,
		ST_INS_SHIFT,
		ST_DEL_SHIFT,
		ST_SCAN,
		ST_OUT
	} state_t;

	localparam logic [1:0] GRP_NONE = 2'd3;

	function automatic logic status_ok(input logic [7:0] s);
		return s == 8'h50 || s == 8'h49 || s == 8'h43 ||
		       s == 8'h70 || s == 8'h69 || s == 8'h63;
	endfunction

	function automatic logic [1:0] group_of(input logic [7:0] s);
		if (s == 8'h50 || s == 8'h70) return 2'd0;
		if (s == 8'h49 || s == 8'h69) return 2'd1;
		if (s == 8'h43 || s == 8'h63) return 2'd2;
		return GRP_NONE;
	endfunction
endpackage
`default_nettype wire

[hdl/priority_sorted_task_table_core.sv]
// Top level of the priority-sorted task table: table registers, sequencer,
// output register. Depends on pstt_pkg.
`default_nettype none
// A request is taken on s_axis when the block is idle. The block then walks
// the table one entry per cycle with a single compare/move unit, except that
// the search and list-all scan waits while the output register holds an
// unaccepted result, and emits its results on m_axis, with tlast on the final
// one. Insert goes through find, position, shift and report; delete through
// find, shift and report; update and a rejected insert or delete through find
// and report. Search checks the priority first and rejects a bad one without
// scanning. The report step also waits for a free output register.
// s_axis_tready is high only in idle. The final result may still wait in the
// output register while the next request starts. With 16 entries the longest
// request is list-all of a full table, with up to 18 results. Unknown request
// types are dropped with no result.
module priority_sorted_task_table_core
	import pstt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [2:0] req_type, [18:3] task_id, [21:19] priority_req, [29:22] status_char
	input  wire logic [31:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [2:0] result_code, [3] entry_present, [19:4] entry_id,
	// [22:20] entry_priority, [30:23] entry_status, [32:31] status_group
	output logic [39:0]      m_axis_tdata,
	output logic             m_axis_tlast
);
	logic [15:0] ids_q [Depth];
	logic [2:0]  pris_q [Depth];
	logic [7:0]  sts_q [Depth];
	logic [CntW-1:0] cnt_q;

	state_t state_q, state_d;
	logic [2:0]  req_q;
	logic [15:0] id_q;
	logic [2:0]  pri_q;
	logic [7:0]  st_q;
	logic [CntW-1:0] i_q, i_d;   // scan pointer
	logic [CntW-1:0] pos_q;      // insert position
	logic [1:0]  grp_q, grp_d;
	logic        hold_q, hold_d; // a match of the current pass is held back
	logic [IdxW-1:0] hidx_q, hidx_d; // index of the held match
	logic [2:0]  code_q;         // code of the single result of the request

	// output register
	logic        ov_q;
	logic [2:0]  orc_q;
	logic        opres_q;
	logic [15:0] oid_q;
	logic [2:0]  opri_q;
	logic [7:0]  ost_q;
	logic [1:0]  ogrp_q;
	logic        olast_q;

	logic take;
	logic out_free;
	logic [IdxW-1:0] ix;
	logic cur_match;
	logic scan_end;

	// emission request from the sequencer
	logic        emit;
	logic [2:0]  e_rc;
	logic        e_pres;
	logic [1:0]  e_grp;
	logic        e_last;
	// table write controls
	logic        do_ins_mv, do_ins_wr, do_del_mv, do_upd, cnt_inc, cnt_dec;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign take = s_axis_tvalid && s_axis_tready;
	assign out_free = !ov_q || m_axis_tready;
	assign ix = i_q[IdxW-1:0];
	assign scan_end = (i_q >= cnt_q);

	always_comb begin
		cur_match = 1'b0;
		if (req_q == REQ_SEARCH) cur_match = (pris_q[ix] == pri_q);
		else cur_match = (group_of(sts_q[ix]) == grp_q);
	end

	always_comb begin
		state_d = state_q;
		i_d = i_q;
		grp_d = grp_q;
		hold_d = hold_q;
		hidx_d = hidx_q;
		emit = 1'b0;
		e_rc = RC_OK;
		e_pres = 1'b0;
		e_grp = 2'd0;
		e_last = 1'b1;
		do_ins_mv = 1'b0;
		do_ins_wr = 1'b0;
		do_del_mv = 1'b0;
		do_upd = 1'b0;
		cnt_inc = 1'b0;
		cnt_dec = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					i_d = '0;
					grp_d = 2'd0;
					hold_d = 1'b0;
					case (s_axis_tdata[2:0])
						REQ_INSERT, REQ_DELETE, REQ_UPDATE: state_d = ST_FIND;
						REQ_SEARCH, REQ_LIST: state_d = ST_SCAN;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_FIND: begin
				// walk for the id; decide once found or at the end
				if (!scan_end && ids_q[ix] != id_q) begin
					i_d = i_q + 1'b1;
				end else begin
					state_d = ST_OUT;
					case (req_q)
						REQ_INSERT: begin
							if (!status_ok(st_q)) e_rc = RC_BAD_STATUS;
							else if (!scan_end) e_rc = RC_DUPLICATE;
							else if (cnt_q >= CntW'(Depth)) e_rc = RC_FULL;
							else begin
								state_d = ST_INS_POS;
								i_d = '0;
							end
						end
						REQ_DELETE: begin
							if (cnt_q == '0) e_rc = RC_EMPTY;
							else if (scan_end) e_rc = RC_NOT_FOUND;
							else state_d = ST_DEL_SHIFT;
						end
						default: begin
							if (!status_ok(st_q)) e_rc = RC_BAD_STATUS;
							else if (scan_end) e_rc = RC_NOT_FOUND;
							else do_upd = 1'b1;
						end
					endcase
				end
			end
			ST_INS_POS: begin
				// front if first priority >= new, else after all <= new
				if (!scan_end && (i_q == '0 ? pris_q[ix] < pri_q : pris_q[ix] <= pri_q))
					i_d = i_q + 1'b1;
				else begin
					i_d = cnt_q;
					state_d = ST_INS_SHIFT;
				end
			end
			ST_INS_SHIFT: begin
				if (i_q > pos_q) begin
					do_ins_mv = 1'b1;
					i_d = i_q - 1'b1;
				end else begin
					do_ins_wr = 1'b1;
					cnt_inc = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_DEL_SHIFT: begin
				if (i_q + 1'b1 < cnt_q) begin
					do_del_mv = 1'b1;
					i_d = i_q + 1'b1;
				end else begin
					cnt_dec = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_SCAN: begin
				if (req_q == REQ_SEARCH && (pri_q < 3'd1 || pri_q > 3'd5)) begin
					e_rc = RC_BAD_PRIORITY;
					state_d = ST_OUT;
				end else if (out_free) begin
					e_grp = (req_q == REQ_LIST) ? grp_q : 2'd0;
					if (!scan_end) begin
						i_d = i_q + 1'b1;
						if (cur_match) begin
							// a later match exists, so release the held one as not-last
							// and hold this one in its place
							emit = hold_q;
							e_pres = 1'b1;
							e_last = 1'b0;
							hold_d = 1'b1;
							hidx_d = ix;
						end
					end else begin
						// end of a pass: release the held match as the final one of
						// the group, or a marker when the group had none
						emit = 1'b1;
						e_pres = hold_q;
						e_rc = hold_q ? RC_OK : RC_NONE;
						e_last = (req_q != REQ_LIST) || grp_q == 2'd2;
						hold_d = 1'b0;
						if (req_q == REQ_LIST && grp_q != 2'd2) begin
							grp_d = grp_q + 1'b1;
							i_d = '0;
						end else begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			ST_OUT: begin
				e_rc = code_q;
				if (out_free) begin
					emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) cnt_q <= cnt_q + 1'b1;
			if (cnt_dec) cnt_q <= cnt_q - 1'b1;
			if (emit) ov_q <= 1'b1;
			else if (m_axis_tready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		i_q <= i_d;
		grp_q <= grp_d;
		hold_q <= hold_d;
		hidx_q <= hidx_d;
		if (take) begin
			req_q <= s_axis_tdata[2:0];
			id_q <= s_axis_tdata[18:3];
			pri_q <= s_axis_tdata[21:19];
			st_q <= s_axis_tdata[29:22];
		end
		if (state_q == ST_INS_POS) pos_q <= i_q;
		// stage the code of a single-result request until the output is free
		if ((state_q == ST_FIND || state_q == ST_SCAN) && state_d == ST_OUT)
			code_q <= e_rc;
		if (do_upd) sts_q[ix] <= st_q;
		if (do_ins_mv) begin
			ids_q[ix] <= ids_q[IdxW'(i_q - 1'b1)];
			pris_q[ix] <= pris_q[IdxW'(i_q - 1'b1)];
			sts_q[ix] <= sts_q[IdxW'(i_q - 1'b1)];
		end
		if (do_ins_wr) begin
			ids_q[ix] <= id_q;
			pris_q[ix] <= pri_q;
			sts_q[ix] <= st_q;
			code_q <= RC_OK;
		end
		if (do_del_mv) begin
			ids_q[ix] <= ids_q[IdxW'(i_q + 1'b1)];
			pris_q[ix] <= pris_q[IdxW'(i_q + 1'b1)];
			sts_q[ix] <= sts_q[IdxW'(i_q + 1'b1)];
		end
		if (cnt_dec) code_q <= RC_OK;
		if (emit) begin
			orc_q <= e_rc;
			opres_q <= e_pres;
			oid_q <= e_pres ? ids_q[hidx_q] : 16'd0;
			opri_q <= e_pres ? pris_q[hidx_q] : 3'd0;
			ost_q <= e_pres ? sts_q[hidx_q] : 8'd0;
			ogrp_q <= e_grp;
			olast_q <= e_last;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tlast = olast_q;
	assign m_axis_tdata = {7'd0, ogrp_q, ost_q, opri_q, oid_q, opres_q, orc_q};

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(Depth)) else $error("count overflow");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("result lost");
endmodule
`default_nettype wire
